>>> src/csp_variable_selector_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the variable selector
// Shared property shapes, clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef CSP_VARIABLE_SELECTOR_DEFINES_SVH
`define CSP_VARIABLE_SELECTOR_DEFINES_SVH

// Same-cycle implication: cond holds whenever trig holds.
`define CSV_ASSERT_NOW(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("csp_variable_selector: same-cycle check failed");

// Next-cycle implication: cond holds in the cycle after trig.
`define CSV_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("csp_variable_selector: next-cycle check failed");

`endif

>>> src/csp_vsel_pkg.sv
// ----------------------------------------------------------------------------
// csp_vsel_pkg
// Beat types, ordering modes, result codes and value limits of the selector.
// ----------------------------------------------------------------------------
package csp_vsel_pkg;

  // Value limits
  localparam logic [10:0] MAX_DOMAIN    = 11'd1024;
  localparam logic [2:0]  DEG_TOP       = 3'd4;
  localparam logic [10:0] SIZE_SENTINEL = 11'h7FF;

  // Ordering modes held in the mode register
  typedef enum logic [1:0] {
    MODE_MRV_DEG = 2'd0,
    MODE_MRV     = 2'd1,
    MODE_FIRST   = 2'd2,
    MODE_DEGREE  = 2'd3
  } mode_e_t;

  // Result codes
  typedef enum logic [1:0] {
    ST_CHOSEN       = 2'd0,
    ST_FAILURE      = 2'd1,
    ST_COMPLETE     = 2'd2,
    ST_NO_CANDIDATE = 2'd3
  } status_t;

  // One input beat: a grid cell
  typedef struct packed {
    logic [3:0]  cell_x;
    logic [3:0]  cell_y;
    logic        cell_assigned;
    logic [10:0] cell_domain_size;
    logic [2:0]  cell_degree;
    logic        last_cell;
  } cell_beat_t;

  // One output beat: the selection
  typedef struct packed {
    logic [3:0]  sel_x;
    logic [3:0]  sel_y;
    logic [10:0] sel_domain_size;
    logic [2:0]  sel_degree;
    status_t     status;
  } sel_beat_t;

endpackage

>>> src/csp_variable_selector.sv
// ----------------------------------------------------------------------------
// csp_variable_selector: picks the next grid cell to branch on
// Result beat: registered, valid in the cycle after the accepted last cell.
// Throughput: 1 cell per cycle; input stalls only while a result beat waits.
// Reset: synchronous; clears scan state, mode to 0, no result pending.
// ----------------------------------------------------------------------------
`include "csp_variable_selector_defines.svh"

module csp_variable_selector (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [1:0]              cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  csp_vsel_pkg::cell_beat_t in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output csp_vsel_pkg::sel_beat_t  out_data
);

  // Mode register
  csp_vsel_pkg::mode_e_t mode;

  // Scan state
  logic [3:0]  best_x;
  logic [3:0]  best_y;
  logic [10:0] best_size;
  logic [2:0]  best_degree;
  logic        seen_unassigned;
  logic        decided_flag;
  logic        failure_flag;

  logic [3:0]  best_x_next;
  logic [3:0]  best_y_next;
  logic [10:0] best_size_next;
  logic [2:0]  best_degree_next;
  logic        seen_unassigned_next;
  logic        decided_flag_next;
  logic        failure_flag_next;

  logic        in_fire;
  logic        active;
  logic        take;
  logic [10:0] size_clamped;
  logic [2:0]  degree_clamped;
  csp_vsel_pkg::sel_beat_t result;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Clamp out-of-range size and degree before any compare
  assign size_clamped   = (in_data.cell_domain_size > csp_vsel_pkg::MAX_DOMAIN) ?
                          csp_vsel_pkg::MAX_DOMAIN : in_data.cell_domain_size;
  assign degree_clamped = (in_data.cell_degree > csp_vsel_pkg::DEG_TOP) ?
                          csp_vsel_pkg::DEG_TOP : in_data.cell_degree;

  // Only unassigned cells count, and only until failure or a first-cell pick
  assign active = !failure_flag && !decided_flag && !in_data.cell_assigned;

  // Decide whether this cell replaces the current best
  always_comb begin
    take = 1'b0;
    unique case (mode)
      csp_vsel_pkg::MODE_MRV_DEG: begin
        take = !seen_unassigned || (size_clamped < best_size) ||
               ((size_clamped == best_size) && (degree_clamped > best_degree));
      end
      csp_vsel_pkg::MODE_MRV: begin
        take = !seen_unassigned || (size_clamped < best_size);
      end
      csp_vsel_pkg::MODE_FIRST: begin
        take = 1'b1;
      end
      csp_vsel_pkg::MODE_DEGREE: begin
        take = degree_clamped > best_degree;
      end
      default: begin
        take = 1'b0;
      end
    endcase
  end

  // Next scan state for this cell
  always_comb begin
    best_x_next          = best_x;
    best_y_next          = best_y;
    best_size_next       = best_size;
    best_degree_next     = best_degree;
    seen_unassigned_next = seen_unassigned;
    decided_flag_next    = decided_flag;
    failure_flag_next    = failure_flag;
    if (active) begin
      seen_unassigned_next = 1'b1;
      if (in_data.cell_domain_size == 11'd0) begin
        failure_flag_next = 1'b1;
        best_x_next       = in_data.cell_x;
        best_y_next       = in_data.cell_y;
      end else begin
        if (take) begin
          best_x_next      = in_data.cell_x;
          best_y_next      = in_data.cell_y;
          best_size_next   = size_clamped;
          best_degree_next = degree_clamped;
        end
        if (mode == csp_vsel_pkg::MODE_FIRST) begin
          decided_flag_next = 1'b1;
        end
      end
    end
  end

  // Build the result from the updated scan state
  always_comb begin
    result.sel_x           = 4'd0;
    result.sel_y           = 4'd0;
    result.sel_domain_size = 11'd0;
    result.sel_degree      = 3'd0;
    result.status          = csp_vsel_pkg::ST_CHOSEN;
    if (failure_flag_next) begin
      result.sel_x  = best_x_next;
      result.sel_y  = best_y_next;
      result.status = csp_vsel_pkg::ST_FAILURE;
    end else if (!seen_unassigned_next) begin
      result.status = csp_vsel_pkg::ST_COMPLETE;
    end else if ((mode == csp_vsel_pkg::MODE_DEGREE) && (best_degree_next == 3'd0)) begin
      result.status = csp_vsel_pkg::ST_NO_CANDIDATE;
    end else begin
      result.sel_x           = best_x_next;
      result.sel_y           = best_y_next;
      result.sel_domain_size = best_size_next;
      result.sel_degree      = best_degree_next;
    end
  end

  // Hold the mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= csp_vsel_pkg::MODE_MRV_DEG;
    end else if (cfg_wr_en) begin
      mode <= csp_vsel_pkg::mode_e_t'(cfg_wr_data);
    end
  end

  // Advance scan state; drop back to the start values after the last cell
  always_ff @(posedge clk) begin
    if (rst || (in_fire && in_data.last_cell)) begin
      best_x          <= 4'd0;
      best_y          <= 4'd0;
      best_size       <= csp_vsel_pkg::SIZE_SENTINEL;
      best_degree     <= 3'd0;
      seen_unassigned <= 1'b0;
      decided_flag    <= 1'b0;
      failure_flag    <= 1'b0;
    end else if (in_fire) begin
      best_x          <= best_x_next;
      best_y          <= best_y_next;
      best_size       <= best_size_next;
      best_degree     <= best_degree_next;
      seen_unassigned <= seen_unassigned_next;
      decided_flag    <= decided_flag_next;
      failure_flag    <= failure_flag_next;
    end
  end

  // Result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && in_data.last_cell) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.last_cell) begin
      out_data <= result;
    end
  end

  // Checks
  `CSV_ASSERT_NEXT(a_last_gives_result, clk, rst, in_fire && in_data.last_cell, out_valid)
  `CSV_ASSERT_NOW(a_zero_fields, clk, rst,
                  out_valid && (out_data.status != csp_vsel_pkg::ST_CHOSEN),
                  (out_data.sel_domain_size == 11'd0) && (out_data.sel_degree == 3'd0))
  `CSV_ASSERT_NOW(a_failure_seen, clk, rst, failure_flag, seen_unassigned && !decided_flag)
  `CSV_ASSERT_NOW(a_decided_seen, clk, rst, decided_flag, seen_unassigned)

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for csp_variable_selector
// Streams grid-cell scans through the selector under every ordering mode,
// predicts each selection beat and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;

  // Track scan state and hold the selections still owed by the block
  class pick_board;
    csp_vsel_pkg::mode_e_t   mode = csp_vsel_pkg::MODE_MRV_DEG;
    logic [3:0]              best_x = '0;
    logic [3:0]              best_y = '0;
    logic [10:0]             best_size = csp_vsel_pkg::SIZE_SENTINEL;
    logic [2:0]              best_deg = '0;
    bit                      seen_free = 1'b0;
    bit                      decided = 1'b0;
    bit                      failed = 1'b0;
    csp_vsel_pkg::sel_beat_t expected_picks[$];
    int                      errors = 0;

    function void restart();
      best_x    = '0;
      best_y    = '0;
      best_size = csp_vsel_pkg::SIZE_SENTINEL;
      best_deg  = '0;
      seen_free = 1'b0;
      decided   = 1'b0;
      failed    = 1'b0;
    endfunction

    function void take(logic [3:0] x, logic [3:0] y, logic [10:0] sz, logic [2:0] dg);
      best_x    = x;
      best_y    = y;
      best_size = sz;
      best_deg  = dg;
    endfunction

    function int pending();
      return expected_picks.size();
    endfunction

    // Fold one accepted cell into the scan; queue a selection on the last cell
    function void note_cell(csp_vsel_pkg::cell_beat_t c);
      logic [10:0]             sz;
      logic [2:0]              dg;
      bit                      first;
      csp_vsel_pkg::sel_beat_t r;
      sz = (c.cell_domain_size > csp_vsel_pkg::MAX_DOMAIN) ?
           csp_vsel_pkg::MAX_DOMAIN : c.cell_domain_size;
      dg = (c.cell_degree > csp_vsel_pkg::DEG_TOP) ? csp_vsel_pkg::DEG_TOP : c.cell_degree;
      if (!failed && !decided && !c.cell_assigned) begin
        if (c.cell_domain_size == '0) begin
          // latch the empty-domain cell
          failed    = 1'b1;
          best_x    = c.cell_x;
          best_y    = c.cell_y;
          seen_free = 1'b1;
        end else begin
          first     = !seen_free;
          seen_free = 1'b1;
          case (mode)
            csp_vsel_pkg::MODE_MRV_DEG: begin
              if (first || sz < best_size || (sz == best_size && dg > best_deg))
                take(c.cell_x, c.cell_y, sz, dg);
            end
            csp_vsel_pkg::MODE_MRV: begin
              if (first || sz < best_size)
                take(c.cell_x, c.cell_y, sz, dg);
            end
            csp_vsel_pkg::MODE_FIRST: begin
              take(c.cell_x, c.cell_y, sz, dg);
              decided = 1'b1;
            end
            default: begin
              if (dg > best_deg)
                take(c.cell_x, c.cell_y, sz, dg);
            end
          endcase
        end
      end
      if (c.last_cell) begin
        r = '0;
        if (failed) begin
          r.sel_x  = best_x;
          r.sel_y  = best_y;
          r.status = csp_vsel_pkg::ST_FAILURE;
        end else if (!seen_free) begin
          r.status = csp_vsel_pkg::ST_COMPLETE;
        end else if (mode == csp_vsel_pkg::MODE_DEGREE && best_deg == '0) begin
          r.status = csp_vsel_pkg::ST_NO_CANDIDATE;
        end else begin
          r.sel_x           = best_x;
          r.sel_y           = best_y;
          r.sel_domain_size = best_size;
          r.sel_degree      = best_deg;
          r.status          = csp_vsel_pkg::ST_CHOSEN;
        end
        expected_picks.push_back(r);
        restart();
      end
    endfunction

    // Compare one selection beat with the oldest expected one
    function void check_pick(csp_vsel_pkg::sel_beat_t got);
      csp_vsel_pkg::sel_beat_t want;
      if (expected_picks.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected selection beat: x=%0d y=%0d size=%0d deg=%0d st=%0d",
                   got.sel_x, got.sel_y, got.sel_domain_size, got.sel_degree, got.status);
        return;
      end
      want = expected_picks.pop_front();
      if (got.sel_x !== want.sel_x || got.sel_y !== want.sel_y ||
          got.sel_domain_size !== want.sel_domain_size ||
          got.sel_degree !== want.sel_degree || got.status !== want.status) begin
        errors++;
        if (errors <= 10) begin
          $display("selection mismatch: want x=%0d y=%0d size=%0d deg=%0d st=%0d",
                   want.sel_x, want.sel_y, want.sel_domain_size, want.sel_degree,
                   want.status);
          $display("                    got  x=%0d y=%0d size=%0d deg=%0d st=%0d",
                   got.sel_x, got.sel_y, got.sel_domain_size, got.sel_degree,
                   got.status);
        end
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_wr_en = 1'b0;
  logic [1:0]               cfg_wr_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  csp_vsel_pkg::cell_beat_t in_data = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  csp_vsel_pkg::sel_beat_t  out_data;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;

  pick_board board = new;

  csp_variable_selector dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Drive ready: honor a long hold-off request, else stall at random
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watch both channels for beats
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      board.note_cell(in_data);
    if (!rst && out_valid && out_ready)
      board.check_pick(out_data);
  end

  function automatic csp_vsel_pkg::cell_beat_t grid_cell(input int x, input int y,
                                                         input bit asg, input int sz,
                                                         input int dg, input bit last);
    csp_vsel_pkg::cell_beat_t c;
    c.cell_x           = 4'(x);
    c.cell_y           = 4'(y);
    c.cell_assigned    = asg;
    c.cell_domain_size = 11'(sz);
    c.cell_degree      = 3'(dg);
    c.last_cell        = last;
    return c;
  endfunction

  // Mostly small domains and in-range degrees so ties happen often
  function automatic csp_vsel_pkg::cell_beat_t random_cell(input bit last);
    csp_vsel_pkg::cell_beat_t c;
    int                       pick;
    c.cell_x        = 4'($urandom);
    c.cell_y        = 4'($urandom);
    c.cell_assigned = ($urandom_range(99) < 30);
    pick = $urandom_range(99);
    if (pick < 5)
      c.cell_domain_size = '0;
    else if (pick < 70)
      c.cell_domain_size = 11'($urandom_range(6, 1));
    else if (pick < 90)
      c.cell_domain_size = 11'($urandom_range(1024, 1));
    else
      c.cell_domain_size = 11'($urandom_range(2047, 1000));
    c.cell_degree = ($urandom_range(99) < 85) ? 3'($urandom_range(4, 0)) :
                                                3'($urandom_range(7, 5));
    c.last_cell   = last;
    return c;
  endfunction

  // Offer one cell, idling first at random, and wait for the beat
  task automatic send_cell(input csp_vsel_pkg::cell_beat_t c);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and wait until every selection is back, plus a short margin
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input csp_vsel_pkg::mode_e_t m);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    board.mode = m;
    cfg_wr_en <= 1'b0;
  endtask

  // Send well-formed scans with random content, mixed with raw noise cells
  task automatic run_scans(input int n);
    int                       left;
    int                       len;
    csp_vsel_pkg::cell_beat_t c;
    left = n;
    while (left > 0) begin
      if ($urandom_range(99) < 10) begin
        c = csp_vsel_pkg::cell_beat_t'($urandom);
        send_cell(c);
        left--;
      end else begin
        len = ($urandom_range(99) < 85) ? $urandom_range(8, 1) : $urandom_range(30, 9);
        for (int i = 1; i <= len && left > 0; i++) begin
          send_cell(random_cell(i == len));
          left--;
        end
      end
    end
  endtask

  // Hold the receiver off while one-cell scans keep coming, then drain
  task automatic flood(input int n);
    hold_req <= hold_req + 1;
    repeat (n) send_cell(random_cell(1'b1));
    settle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Fewest values with degree tie-break: clamping, ties, failure, all assigned
    write_mode(csp_vsel_pkg::MODE_MRV_DEG);
    send_cell(grid_cell(15, 15, 1, 2047, 7, 0));
    send_cell(grid_cell(3, 0, 0, 2047, 7, 0));
    send_cell(grid_cell(4, 0, 0, 1024, 0, 0));
    send_cell(grid_cell(0, 1, 0, 1, 4, 0));
    send_cell(grid_cell(1, 1, 0, 1, 4, 0));
    send_cell(grid_cell(2, 1, 0, 1, 3, 1));
    send_cell(grid_cell(5, 9, 0, 0, 2, 0));
    send_cell(grid_cell(6, 9, 0, 1, 4, 1));
    send_cell(grid_cell(7, 7, 1, 0, 0, 1));
    send_cell(grid_cell(8, 8, 0, 0, 0, 1));

    // Degree only: no candidate, then a scan left open
    write_mode(csp_vsel_pkg::MODE_DEGREE);
    send_cell(grid_cell(0, 0, 0, 5, 0, 0));
    send_cell(grid_cell(1, 0, 0, 3, 0, 1));
    send_cell(grid_cell(0, 2, 0, 5, 2, 0));
    send_cell(grid_cell(1, 2, 0, 9, 6, 0));

    // Switch to first-unassigned mid-scan; later cells change nothing
    write_mode(csp_vsel_pkg::MODE_FIRST);
    send_cell(grid_cell(2, 2, 1, 4, 1, 0));
    send_cell(grid_cell(3, 2, 0, 7, 1, 0));
    send_cell(grid_cell(4, 2, 0, 0, 4, 1));

    // Fewest values only: degree never breaks ties
    write_mode(csp_vsel_pkg::MODE_MRV);
    send_cell(grid_cell(9, 3, 0, 1024, 1, 0));
    send_cell(grid_cell(10, 3, 0, 3, 0, 0));
    send_cell(grid_cell(11, 3, 0, 3, 4, 0));
    send_cell(grid_cell(12, 3, 1, 1, 4, 1));

    // Random scans in three idling phases, changing mode between segments
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 62 : 0;
      rx_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 29 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        if (seg == 0)
          write_mode(csp_vsel_pkg::MODE_MRV_DEG);
        else if (seg == 3)
          write_mode(csp_vsel_pkg::MODE_DEGREE);
        else
          write_mode(csp_vsel_pkg::mode_e_t'($urandom_range(3)));
        if (phase == 2 && seg == 1) begin
          flood(24);
          run_scans(72);
        end else begin
          run_scans(96);
        end
      end
    end

    settle();
    if (board.errors == 0 && board.pending() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
